>>> design/arc_pkg.sv
// ----------------------------------------------------------------------------
// arc_pkg
// Shared types and constants for the ARP responder with address cache.
// ----------------------------------------------------------------------------
package arc_pkg;

  localparam int IP_W  = 32;
  localparam int MAC_W = 48;

  // input word kinds
  localparam logic OPC_HEADER = 1'b0;
  localparam logic OPC_LOOKUP = 1'b1;

  // frame kinds on the result channel
  localparam logic [1:0] FRAME_NONE    = 2'd0;
  localparam logic [1:0] FRAME_REPLY   = 2'd1;
  localparam logic [1:0] FRAME_REQUEST = 2'd2;

  // header acceptance, network order taken as plain numbers
  localparam logic [15:0] MIN_PAYLOAD_BYTES = 16'd28;
  localparam logic [15:0] HW_TYPE_ETH       = 16'h0001;
  localparam logic [15:0] PROTO_TYPE_IPV4   = 16'h0800;
  localparam logic [7:0]  HW_LEN_ETH        = 8'd6;
  localparam logic [7:0]  PROTO_LEN_IPV4    = 8'd4;
  localparam logic [15:0] OPER_REQUEST      = 16'd1;
  localparam logic [15:0] OPER_REPLY        = 16'd2;

  localparam logic [MAC_W-1:0] MAC_BCAST = {MAC_W{1'b1}};

  // register select, one bit of paddr
  localparam logic REG_OWN_IP  = 1'b0;
  localparam logic REG_OWN_MAC = 1'b1;

  // lookup token travelling down the row of cells
  typedef struct packed {
    logic             live;
    logic [IP_W-1:0]  ip;
    logic             hit;
    logic [MAC_W-1:0] mac;
  } tok_t;

  // append request broadcast to all cells
  typedef struct packed {
    logic             en;
    logic [IP_W-1:0]  ip;
    logic [MAC_W-1:0] mac;
  } wr_t;

  typedef struct packed {
    logic [1:0]       frame_kind;
    logic [MAC_W-1:0] frame_target_mac;
    logic [IP_W-1:0]  frame_target_ip;
    logic             lookup_hit;
    logic [MAC_W-1:0] lookup_mac;
    logic             cache_written;
    logic             cache_full;
  } res_t;

endpackage

>>> design/arc_cell.sv
// ----------------------------------------------------------------------------
// arc_cell
// One cache entry plus one stage of the lookup token path.
// ----------------------------------------------------------------------------
module arc_cell import arc_pkg::*; #(
  parameter int IDX_W    = 7,
  parameter int CNT_W    = 8,
  parameter int CELL_IDX = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  wr_t              wr,
  input  logic [IDX_W-1:0] wr_idx,
  input  logic [CNT_W-1:0] count,
  input  tok_t             tok_in,
  output tok_t             tok_out
);

  logic [IP_W-1:0]  ip_r;
  logic [MAC_W-1:0] mac_r;
  tok_t             tok_r;
  tok_t             tok_nxt;
  logic             cell_wr;
  logic             match;

  assign cell_wr = wr.en && (wr_idx == IDX_W'(CELL_IDX));

  // only entries below the fill count take part
  assign match = tok_in.live && !tok_in.hit && (count > CNT_W'(CELL_IDX))
                 && (ip_r == tok_in.ip);

  always_comb begin
    tok_nxt = tok_in;
    if (match) begin
      tok_nxt.hit = 1'b1;
      tok_nxt.mac = mac_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cell_wr) begin
      ip_r  <= wr.ip;
      mac_r <= wr.mac;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule

>>> design/arp_responder_cache_core.sv
// ----------------------------------------------------------------------------
// arp_responder_cache_core
// ARP responder with an append-only address cache held in a row of cells.
// ----------------------------------------------------------------------------
//
//  channel   handshake               payload
//  in        in_valid / in_ready     in_opcode .. in_lookup_ip
//  out       out_valid / out_ready   out_frame_kind .. out_cache_full
//  cfg       psel/penable/pready     paddr[3] selects own_ip / own_mac
//
//  a header word gives its result in the cycle after it is taken
//  a lookup token steps one cell a cycle, is parked in tail_r, then goes to res_r
//  one word is in work at a time; in_ready waits for idle and a free output register
//  reset empties the cache (fill count to zero) and clears both registers
//
module arp_responder_cache_core import arc_pkg::*; #(
  parameter int CACHE_ENTRIES = 128
) (
  input  logic              clk,
  input  logic              rst_n,
  // input channel
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_opcode,
  input  logic [15:0]       in_payload_size,
  input  logic [15:0]       in_hw_type,
  input  logic [15:0]       in_proto_type,
  input  logic [7:0]        in_hw_len,
  input  logic [7:0]        in_proto_len,
  input  logic [15:0]       in_oper,
  input  logic [MAC_W-1:0]  in_sender_mac,
  input  logic [IP_W-1:0]   in_sender_ip,
  input  logic [IP_W-1:0]   in_target_ip,
  input  logic [IP_W-1:0]   in_lookup_ip,
  // result channel
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_frame_kind,
  output logic [MAC_W-1:0]  out_frame_target_mac,
  output logic [IP_W-1:0]   out_frame_target_ip,
  output logic              out_lookup_hit,
  output logic [MAC_W-1:0]  out_lookup_mac,
  output logic              out_cache_written,
  output logic              out_cache_full,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [63:0]       pwdata,
  output logic [63:0]       prdata,
  output logic              pready
);

  localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(CACHE_ENTRIES + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [IP_W-1:0]  own_ip_r;
  logic [MAC_W-1:0] own_mac_r;
  logic [CNT_W-1:0] count_r;
  logic             out_valid_r;
  res_t             res_r, res_nxt;
  tok_t             tail_r;

  logic             in_acc;
  logic             out_free;
  logic             cfg_wr;
  logic             hdr_ok;
  logic             cache_room;
  wr_t              wr;
  tok_t             tok_head;
  tok_t             tok_chain [CACHE_ENTRIES];
  tok_t             tok_tail;
  res_t             hdr_res;
  res_t             look_res;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;
  assign prdata   = (paddr[3] == REG_OWN_MAC) ? {16'd0, own_mac_r} : {32'd0, own_ip_r};

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == ST_IDLE) && out_free;
  assign in_acc   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_ip_r  <= '0;
      own_mac_r <= '0;
    end else if (cfg_wr) begin
      if (paddr[3] == REG_OWN_MAC) begin
        own_mac_r <= pwdata[MAC_W-1:0];
      end else begin
        own_ip_r  <= pwdata[IP_W-1:0];
      end
    end
  end

  // header checks
  assign hdr_ok = (in_payload_size >= MIN_PAYLOAD_BYTES) && (in_hw_type == HW_TYPE_ETH)
                  && (in_proto_type == PROTO_TYPE_IPV4) && (in_hw_len == HW_LEN_ETH)
                  && (in_proto_len == PROTO_LEN_IPV4) && (in_target_ip == own_ip_r);
  assign cache_room = (count_r < CNT_W'(CACHE_ENTRIES));

  always_comb begin
    hdr_res = '0;
    if (hdr_ok) begin
      if (in_oper == OPER_REQUEST) begin
        hdr_res.frame_kind       = FRAME_REPLY;
        hdr_res.frame_target_mac = in_sender_mac;
        hdr_res.frame_target_ip  = in_sender_ip;
      end else if (in_oper == OPER_REPLY) begin
        hdr_res.cache_written = cache_room;
        hdr_res.cache_full    = !cache_room;
      end
    end
  end

  // append at the fill count
  assign wr.en  = in_acc && (in_opcode == OPC_HEADER) && hdr_ok
                  && (in_oper == OPER_REPLY) && cache_room;
  assign wr.ip  = in_sender_ip;
  assign wr.mac = in_sender_mac;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (wr.en) begin
      count_r <= count_r + CNT_W'(1);
    end
  end

  assign tok_head.live = in_acc && (in_opcode == OPC_LOOKUP);
  assign tok_head.ip   = in_lookup_ip;
  assign tok_head.hit  = 1'b0;
  assign tok_head.mac  = MAC_BCAST;

  for (genvar g = 0; g < CACHE_ENTRIES; g++) begin : g_cell
    tok_t cell_in;
    if (g == 0) begin : g_head
      assign cell_in = tok_head;
    end else begin : g_link
      assign cell_in = tok_chain[g-1];
    end
    arc_cell #(
      .IDX_W    (IDX_W),
      .CNT_W    (CNT_W),
      .CELL_IDX (g)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .wr      (wr),
      .wr_idx  (count_r[IDX_W-1:0]),
      .count   (count_r),
      .tok_in  (cell_in),
      .tok_out (tok_chain[g])
    );
  end

  assign tok_tail = tok_chain[CACHE_ENTRIES-1];

  // token leaving the last cell is parked until the output register frees
  always_ff @(posedge clk) begin
    if (tok_tail.live) begin
      tail_r <= tok_tail;
    end
  end

  always_comb begin
    look_res = '0;
    if (tail_r.hit) begin
      look_res.lookup_hit = 1'b1;
      look_res.lookup_mac = tail_r.mac;
    end else begin
      look_res.frame_kind       = FRAME_REQUEST;
      look_res.frame_target_mac = MAC_BCAST;
      look_res.frame_target_ip  = tail_r.ip;
      look_res.lookup_mac       = MAC_BCAST;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_opcode == OPC_LOOKUP)) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (tok_tail.live) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    res_nxt = res_r;
    if (in_acc && (in_opcode == OPC_HEADER)) begin
      res_nxt = hdr_res;
    end else if ((state_r == ST_DONE) && out_free) begin
      res_nxt = look_res;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((in_acc && (in_opcode == OPC_HEADER)) || ((state_r == ST_DONE) && out_free)) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_frame_kind       = res_r.frame_kind;
  assign out_frame_target_mac = res_r.frame_target_mac;
  assign out_frame_target_ip  = res_r.frame_target_ip;
  assign out_lookup_hit       = res_r.lookup_hit;
  assign out_lookup_mac       = res_r.lookup_mac;
  assign out_cache_written    = res_r.cache_written;
  assign out_cache_full       = res_r.cache_full;

endmodule
